@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros used by the blitter rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define FGB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fgb assertion failed");

// next-cycle implication, sampled on clk, off while rst is high
`define FGB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fgb assertion failed");

`endif

@@ rtl/fgb_pkg.sv @@
// ---------------------------------------------------------------------------
// fgb_pkg
// Types, constants and codes shared by the glyph blitter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package fgb_pkg;

  // framebuffer and font geometry
  localparam int LINE_WORDS     = 40;
  localparam int SCREEN_WORDS   = 10240;
  localparam int GLYPH_BYTES    = 4096;
  localparam int OFFSET_ENTRIES = 256;
  localparam int MAX_ROWS       = 16;
  localparam int ROW_CAP        = 16;
  localparam int ROW_LIMIT      = (MAX_ROWS < ROW_CAP) ? MAX_ROWS : ROW_CAP;

  // field and index widths
  localparam int ADDR_W  = 14;
  localparam int OFF_W   = 12;
  localparam int OFF_AW  = $clog2(OFFSET_ENTRIES);
  localparam int GLYPH_AW = $clog2(GLYPH_BYTES);
  localparam int ROW_W   = $clog2(ROW_LIMIT + 1);
  localparam int CFG_AW  = 1;

  // operation codes
  localparam logic [1:0] OP_LOAD_OFFSET = 2'd0;
  localparam logic [1:0] OP_LOAD_GLYPH  = 2'd1;
  localparam logic [1:0] OP_DRAW        = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RANGE   = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_CLIPPED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_FIRST_CODE = 1'd0;
  localparam logic [CFG_AW-1:0] REG_LAST_CODE  = 1'd1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] table_index;
    logic [11:0] load_value;
    logic [7:0]  char_code;
    logic [13:0] target_word;
  } in_t;

  typedef struct packed {
    logic        write_valid;
    logic [13:0] write_address;
    logic [31:0] write_data;
    logic [1:0]  status;
    logic        last;
  } out_t;

endpackage

`default_nettype wire

@@ rtl/fgb_addr_unit.sv @@
// ---------------------------------------------------------------------------
// fgb_addr_unit
// Shared word index adder with one-step wrap at the screen end.
// ---------------------------------------------------------------------------
`default_nettype none

module fgb_addr_unit (
  input  wire logic [fgb_pkg::ADDR_W-1:0] base,
  input  wire logic [fgb_pkg::ADDR_W-1:0] step,
  output logic      [fgb_pkg::ADDR_W-1:0] result
);

  logic [fgb_pkg::ADDR_W:0] sum;

  // base + step stays below twice the screen size, so one subtract wraps it
  always_comb begin
    sum = {1'b0, base} + {1'b0, step};
    if (sum >= (fgb_pkg::ADDR_W + 1)'(fgb_pkg::SCREEN_WORDS)) begin
      sum = sum - (fgb_pkg::ADDR_W + 1)'(fgb_pkg::SCREEN_WORDS);
    end
    result = sum[fgb_pkg::ADDR_W-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/fgb_expand.sv @@
// ---------------------------------------------------------------------------
// fgb_expand
// Turns four pixel bits into four pixel bytes, leftmost pixel lowest.
// ---------------------------------------------------------------------------
`default_nettype none

module fgb_expand (
  input  wire logic [3:0]  pixels,
  output logic      [31:0] word
);

  // bit 3 is the leftmost pixel and lands in byte 0
  always_comb begin
    word = '0;
    for (int k = 0; k < 4; k++) begin
      word[8*k +: 8] = pixels[3-k] ? 8'hFF : 8'h00;
    end
  end

endmodule

`default_nettype wire

@@ rtl/font_glyph_blitter.sv @@
// Draw: two offset reads, one glyph read, then one word per cycle while the
// output does not stall; no new item is taken until the last word is registered.
// Out of range code or empty glyph: a single status result, then the next item.
// Loads: one per cycle while idle, no result. Reset (rst, synchronous) sets
// first_code to 32 and last_code to 127; font stores hold nothing until loaded.
// ---------------------------------------------------------------------------
// font_glyph_blitter
// Byte-per-pixel character blitter: loads font tables, then expands each
// glyph row into two framebuffer word writes under a small sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module font_glyph_blitter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire fgb_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output fgb_pkg::out_t                    out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fgb_pkg::CFG_AW-1:0]  cfg_index,
  input  wire logic [7:0]                  cfg_data
);

`include "assert_macros.svh"

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD0   = 3'd1;
  localparam logic [2:0] S_RD1   = 3'd2;
  localparam logic [2:0] S_RD2   = 3'd3;
  localparam logic [2:0] S_GRD   = 3'd4;
  localparam logic [2:0] S_EMIT0 = 3'd5;
  localparam logic [2:0] S_EMIT1 = 3'd6;
  localparam logic [2:0] S_STAT  = 3'd7;

  logic [2:0] state;

  // configuration registers
  logic [7:0] first_code;
  logic [7:0] last_code;

  // font stores
  logic [fgb_pkg::OFF_W-1:0] offset_mem [fgb_pkg::OFFSET_ENTRIES];
  logic [7:0]                glyph_mem  [fgb_pkg::GLYPH_BYTES];
  logic [fgb_pkg::OFF_W-1:0] off_q;
  logic [7:0]                glyph_q;

  // draw context
  logic [fgb_pkg::OFF_AW-1:0]   idx;
  logic [fgb_pkg::OFF_W-1:0]    start_q;
  logic [fgb_pkg::GLYPH_AW-1:0] gaddr;
  logic [fgb_pkg::ROW_W-1:0]    rows;
  logic [fgb_pkg::ROW_W-1:0]    row_cnt;
  logic                         clipped;
  logic [1:0]                   status_q;
  logic [fgb_pkg::ADDR_W-1:0]   addr;
  logic [fgb_pkg::ADDR_W-1:0]   addr_nb;
  logic [7:0]                   row_q;

  // combinational helpers
  logic                        in_fire;
  logic                        slot_free;
  logic                        code_bad;
  logic [9:0]                  code_diff;
  logic [fgb_pkg::OFF_W-1:0]   row_diff;
  logic [fgb_pkg::ADDR_W-1:0]  unit_base;
  logic [fgb_pkg::ADDR_W-1:0]  unit_step;
  logic [fgb_pkg::ADDR_W-1:0]  unit_res;
  logic [3:0]                  exp_pixels;
  logic [31:0]                 exp_word;
  logic                        row_last;
  logic                        off_rd_en;
  logic [fgb_pkg::OFF_AW-1:0]  off_rd_addr;
  logic                        glyph_rd_en;

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // code range check, including an entry pair that runs off the table
  always_comb begin
    code_diff = {2'b00, in_data.char_code} - {2'b00, first_code} + 10'd1;
    code_bad  = (in_data.char_code < first_code) ||
                (in_data.char_code > last_code) ||
                (code_diff >= 10'(fgb_pkg::OFFSET_ENTRIES));
  end

  assign row_diff = off_q - start_q;
  assign row_last = ((row_cnt + 1'b1) == rows);

  // shared adder operands
  always_comb begin
    unit_base = addr;
    unit_step = '0;
    case (state)
      S_IDLE:  begin
        unit_base = in_data.target_word;
        unit_step = '0;
      end
      S_EMIT0: unit_step = fgb_pkg::ADDR_W'(1);
      S_EMIT1: unit_step = fgb_pkg::ADDR_W'(fgb_pkg::LINE_WORDS);
      default: unit_step = '0;
    endcase
  end

  fgb_addr_unit u_addr (
    .base   (unit_base),
    .step   (unit_step),
    .result (unit_res)
  );

  assign exp_pixels = (state == S_EMIT1) ? row_q[3:0] : glyph_q[7:4];

  fgb_expand u_expand (
    .pixels (exp_pixels),
    .word   (exp_word)
  );

  // store read controls
  always_comb begin
    off_rd_en   = (state == S_RD0) || (state == S_RD1);
    off_rd_addr = (state == S_RD1) ? idx + 1'b1 : idx;
    glyph_rd_en = (state == S_GRD) || ((state == S_EMIT0) && slot_free);
  end

  // offset table: written by load transactions, one registered read port
  always_ff @(posedge clk) begin
    if (in_fire && (in_data.operation == fgb_pkg::OP_LOAD_OFFSET) &&
        ({1'b0, in_data.table_index} < 13'(fgb_pkg::OFFSET_ENTRIES))) begin
      offset_mem[in_data.table_index[fgb_pkg::OFF_AW-1:0]] <= in_data.load_value;
    end
    if (off_rd_en) begin
      off_q <= offset_mem[off_rd_addr];
    end
  end

  // glyph store: written by load transactions, one registered read port
  always_ff @(posedge clk) begin
    if (in_fire && (in_data.operation == fgb_pkg::OP_LOAD_GLYPH) &&
        ({1'b0, in_data.table_index} < 13'(fgb_pkg::GLYPH_BYTES))) begin
      glyph_mem[in_data.table_index[fgb_pkg::GLYPH_AW-1:0]] <= in_data.load_value[7:0];
    end
    if (glyph_rd_en) begin
      glyph_q <= glyph_mem[gaddr];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_code <= 8'd32;
      last_code  <= 8'd127;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fgb_pkg::REG_FIRST_CODE: first_code <= cfg_data;
        fgb_pkg::REG_LAST_CODE:  last_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and draw context
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire && (in_data.operation == fgb_pkg::OP_DRAW)) begin
            addr <= unit_res;
            idx  <= in_data.char_code - first_code;
            if (code_bad) begin
              status_q <= fgb_pkg::STAT_RANGE;
              state    <= S_STAT;
            end else begin
              state <= S_RD0;
            end
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          start_q <= off_q;
          state   <= S_RD2;
        end
        S_RD2: begin
          if (off_q <= start_q) begin
            status_q <= fgb_pkg::STAT_EMPTY;
            state    <= S_STAT;
          end else begin
            if (row_diff > fgb_pkg::OFF_W'(fgb_pkg::ROW_LIMIT)) begin
              rows    <= fgb_pkg::ROW_W'(fgb_pkg::ROW_LIMIT);
              clipped <= 1'b1;
            end else begin
              rows    <= row_diff[fgb_pkg::ROW_W-1:0];
              clipped <= 1'b0;
            end
            row_cnt <= '0;
            gaddr   <= start_q[fgb_pkg::GLYPH_AW-1:0];
            state   <= S_GRD;
          end
        end
        S_GRD: begin
          gaddr <= gaddr + 1'b1;
          state <= S_EMIT0;
        end
        S_EMIT0: begin
          if (slot_free) begin
            row_q   <= glyph_q;
            addr_nb <= unit_res;
            gaddr   <= gaddr + 1'b1;
            state   <= S_EMIT1;
          end
        end
        S_EMIT1: begin
          if (slot_free) begin
            addr    <= unit_res;
            row_cnt <= row_cnt + 1'b1;
            state   <= row_last ? S_IDLE : S_EMIT0;
          end
        end
        S_STAT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free && (state == S_EMIT0 || state == S_EMIT1 ||
                               state == S_STAT)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      case (state)
        S_EMIT0: begin
          out_data.write_valid   <= 1'b1;
          out_data.write_address <= addr;
          out_data.write_data    <= exp_word;
          out_data.status        <= clipped ? fgb_pkg::STAT_CLIPPED : fgb_pkg::STAT_OK;
          out_data.last          <= 1'b0;
        end
        S_EMIT1: begin
          out_data.write_valid   <= 1'b1;
          out_data.write_address <= addr_nb;
          out_data.write_data    <= exp_word;
          out_data.status        <= clipped ? fgb_pkg::STAT_CLIPPED : fgb_pkg::STAT_OK;
          out_data.last          <= row_last;
        end
        S_STAT: begin
          out_data.write_valid   <= 1'b0;
          out_data.write_address <= '0;
          out_data.write_data    <= '0;
          out_data.status        <= status_q;
          out_data.last          <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // checks
  `FGB_ASSERT_NOW(a_status_is_last, out_valid && !out_data.write_valid, out_data.last)
  `FGB_ASSERT_NOW(a_addr_on_screen, out_valid, out_data.write_address < fgb_pkg::ADDR_W'(fgb_pkg::SCREEN_WORDS))
  `FGB_ASSERT_NOW(a_row_in_range, state == S_EMIT0 || state == S_EMIT1, row_cnt < rows)
  `FGB_ASSERT_NEXT(a_draw_holds_input, in_fire && in_data.operation == fgb_pkg::OP_DRAW, in_stall)

endmodule

`default_nettype wire

@@ verif/tb_font_glyph_blitter.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_font_glyph_blitter
// Self-checking bench for the glyph blitter: drives font table loads and
// draw requests with random idle gaps and output stalls, predicts every
// framebuffer write and status result, and compares them in order.
// ---------------------------------------------------------------------------

module tb_font_glyph_blitter;

  localparam int CLK_PERIOD    = 8;
  localparam int GLYPH_ROW_MAX = (fgb_pkg::MAX_ROWS < 16) ? fgb_pkg::MAX_ROWS : 16;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 150;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 36;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    fgb_pkg::in_t  req;
    bit            typed;
    fgb_pkg::out_t result;
  } blit_case_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  fgb_pkg::in_t               in_data   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  fgb_pkg::out_t              out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [fgb_pkg::CFG_AW-1:0] cfg_index = '0;
  logic [7:0]                 cfg_data  = '0;

  // shadow font state and registers
  logic [11:0] glyph_offsets [fgb_pkg::OFFSET_ENTRIES];
  bit          offset_loaded [fgb_pkg::OFFSET_ENTRIES];
  logic [7:0]  glyph_rows    [fgb_pkg::GLYPH_BYTES];
  bit          glyph_loaded  [fgb_pkg::GLYPH_BYTES];
  logic [7:0]  font_first = 8'd32;
  logic [7:0]  font_last  = 8'd127;

  fgb_pkg::out_t pending_fb_writes [$];
  blit_case_t    directed_cases [$];
  int unsigned   mismatch_count = 0;
  int unsigned   items_sent     = 0;
  int unsigned   quiet_cycles   = 0;
  bit            gapless        = 1'b0;
  bit            hold_results   = 1'b0;

  logic [11:0] probe_rows [16] = '{12'hFFF, 12'h000, 12'h080, 12'h001, 12'hF5A, 12'h0A5,
                                   12'h7F0, 12'h00F, 12'hC3C, 12'h03C, 12'hA55, 12'h0AA,
                                   12'h018, 12'hE7E, 12'h081, 12'h5FF};

  font_glyph_blitter u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic fgb_pkg::out_t make_result(bit wr, int unsigned addr,
                                                logic [31:0] data, logic [1:0] st,
                                                bit fin);
    fgb_pkg::out_t res;
    res.write_valid   = wr;
    res.write_address = 14'(addr);
    res.write_data    = data;
    res.status        = st;
    res.last          = fin;
    return res;
  endfunction

  // four pixels of one half row, leftmost pixel in the low byte
  function automatic logic [31:0] pixel_word(logic [7:0] row_bits, bit upper);
    logic [31:0] word;
    logic [3:0]  half;
    int          k;
    word = '0;
    half = upper ? row_bits[7:4] : row_bits[3:0];
    for (k = 0; k < 4; k++) begin
      if (half[3 - k]) word[8*k +: 8] = 8'hFF;
    end
    return word;
  endfunction

  function automatic int unsigned wrap_screen(int unsigned w);
    return (w >= fgb_pkg::SCREEN_WORDS) ? w - fgb_pkg::SCREEN_WORDS : w;
  endfunction

  function automatic bit code_rejected(logic [7:0] code);
    return (code < font_first) || (code > font_last) ||
           (int'(code) - int'(font_first) + 1 >= fgb_pkg::OFFSET_ENTRIES);
  endfunction

  // true when a draw of this code touches only loaded table entries
  function automatic bit draw_reads_loaded(logic [7:0] code);
    int unsigned idx, start, rows, r;
    if (code_rejected(code)) return 1'b1;
    idx = code - font_first;
    if (!offset_loaded[idx] || !offset_loaded[idx + 1]) return 1'b0;
    start = glyph_offsets[idx];
    if (glyph_offsets[idx + 1] <= glyph_offsets[idx]) return 1'b1;
    rows = glyph_offsets[idx + 1] - start;
    if (rows > GLYPH_ROW_MAX) rows = GLYPH_ROW_MAX;
    for (r = 0; r < rows; r++) begin
      if (!glyph_loaded[(start + r) % fgb_pkg::GLYPH_BYTES]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // update the shadow tables and queue the writes one request produces
  task automatic render_request(input fgb_pkg::in_t req);
    int unsigned idx, start, stop, rows, addr, r;
    logic [7:0]  row_bits;
    logic [1:0]  fill_status;
    case (req.operation)
      fgb_pkg::OP_LOAD_OFFSET: begin
        if (req.table_index < fgb_pkg::OFFSET_ENTRIES) begin
          glyph_offsets[req.table_index] = req.load_value;
          offset_loaded[req.table_index] = 1'b1;
        end
      end
      fgb_pkg::OP_LOAD_GLYPH: begin
        glyph_rows[req.table_index % fgb_pkg::GLYPH_BYTES]   = req.load_value[7:0];
        glyph_loaded[req.table_index % fgb_pkg::GLYPH_BYTES] = 1'b1;
      end
      fgb_pkg::OP_DRAW: begin
        if (code_rejected(req.char_code)) begin
          pending_fb_writes.push_back(make_result(1'b0, 0, '0, fgb_pkg::STAT_RANGE, 1'b1));
        end else begin
          idx   = req.char_code - font_first;
          start = glyph_offsets[idx];
          stop  = glyph_offsets[idx + 1];
          if (stop <= start) begin
            pending_fb_writes.push_back(make_result(1'b0, 0, '0, fgb_pkg::STAT_EMPTY,
                                                    1'b1));
          end else begin
            rows        = stop - start;
            fill_status = fgb_pkg::STAT_OK;
            if (rows > GLYPH_ROW_MAX) begin
              rows        = GLYPH_ROW_MAX;
              fill_status = fgb_pkg::STAT_CLIPPED;
            end
            addr = req.target_word % fgb_pkg::SCREEN_WORDS;
            for (r = 0; r < rows; r++) begin
              row_bits = glyph_rows[(start + r) % fgb_pkg::GLYPH_BYTES];
              pending_fb_writes.push_back(make_result(1'b1, addr, pixel_word(row_bits, 1'b1),
                                                      fill_status, 1'b0));
              pending_fb_writes.push_back(make_result(1'b1, wrap_screen(addr + 1),
                                                      pixel_word(row_bits, 1'b0),
                                                      fill_status, r + 1 == rows));
              addr = wrap_screen(addr + fgb_pkg::LINE_WORDS);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // result check
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  // compare each accepted result transaction with the oldest prediction
  always @(posedge clk) begin : fb_write_check
    fgb_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_fb_writes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result with nothing pending, expected none, got 0x%0h",
                   $time, out_data);
      end else begin
        want = pending_fb_writes.pop_front();
        check_field("write_valid", want.write_valid, out_data.write_valid);
        check_field("write_address", want.write_address, out_data.write_address);
        check_field("write_data", want.write_data, out_data.write_data);
        check_field("status", want.status, out_data.status);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  // cycles without any transaction on any channel
  always @(posedge clk) begin : quiet_watch
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stalls, plus a long hold when asked
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned roll, span;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          out_stall <= 1'b0;
          span = $urandom_range(1, 10);
        end else if (roll < 50) begin
          out_stall <= 1'b0;
          span = $urandom_range(30, 80);
        end else if (roll < 90) begin
          out_stall <= 1'b1;
          span = $urandom_range(1, 3);
        end else if (roll < 97) begin
          out_stall <= 1'b1;
          span = $urandom_range(4, 15);
        end else begin
          out_stall <= 1'b1;
          span = $urandom_range(20, 60);
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  function automatic int unsigned sender_gap();
    int unsigned roll;
    if (gapless) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // valid stays high across back-to-back transactions
  task automatic send_request(input fgb_pkg::in_t req, input bit typed = 1'b0,
                              input fgb_pkg::out_t typed_result = '0);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (typed) pending_fb_writes.push_back(typed_result);
    else render_request(req);
    if (req.operation != OP_UNUSED &&
        !(req.operation == fgb_pkg::OP_LOAD_OFFSET &&
          req.table_index >= fgb_pkg::OFFSET_ENTRIES))
      items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_fb_writes.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [fgb_pkg::CFG_AW-1:0] index,
                                input logic [7:0] value);
    cfg_index <= index;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (index == fgb_pkg::REG_FIRST_CODE) font_first = value;
    else font_last = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic fgb_pkg::in_t load_item(logic [1:0] op, int unsigned index,
                                             int unsigned value);
    fgb_pkg::in_t req;
    req.operation   = op;
    req.table_index = 12'(index);
    req.load_value  = 12'(value);
    req.char_code   = 8'($urandom_range(0, 255));
    req.target_word = 14'($urandom_range(0, 16383));
    return req;
  endfunction

  function automatic fgb_pkg::in_t draw_item(logic [7:0] code);
    fgb_pkg::in_t req;
    int unsigned  roll;
    req.operation   = fgb_pkg::OP_DRAW;
    req.table_index = 12'($urandom_range(0, 4095));
    req.load_value  = 12'($urandom_range(0, 4095));
    req.char_code   = code;
    roll = $urandom_range(0, 99);
    // bias toward the screen end so rows and the second word wrap
    if (roll < 20)
      req.target_word = 14'($urandom_range(fgb_pkg::SCREEN_WORDS - 700,
                                           fgb_pkg::SCREEN_WORDS - 1));
    else if (roll < 35)
      req.target_word = 14'($urandom_range(fgb_pkg::SCREEN_WORDS, 16383));
    else
      req.target_word = 14'($urandom_range(0, fgb_pkg::SCREEN_WORDS - 1));
    return req;
  endfunction

  // dropped operations, stray table loads and loads past the offset table
  function automatic fgb_pkg::in_t noise_item();
    case ($urandom_range(0, 3))
      0: return load_item(OP_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 4095));
      1: return load_item(fgb_pkg::OP_LOAD_OFFSET,
                          $urandom_range(fgb_pkg::OFFSET_ENTRIES, 4095),
                          $urandom_range(0, 4095));
      2: return load_item(fgb_pkg::OP_LOAD_OFFSET,
                          $urandom_range(0, fgb_pkg::OFFSET_ENTRIES - 1),
                          $urandom_range(0, 4095));
      default: return load_item(fgb_pkg::OP_LOAD_GLYPH, $urandom_range(0, 4095),
                                $urandom_range(0, 4095));
    endcase
  endfunction

  function automatic int unsigned glyph_height();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 0;
    if (roll < 78) return $urandom_range(1, 8);
    if (roll < 90) return $urandom_range(9, 16);
    return $urandom_range(17, 40);
  endfunction

  // load a run of adjacent glyphs: offsets first, then their row bytes
  task automatic build_font(output int unsigned lo_idx, output int unsigned glyphs);
    int unsigned base_code, pos, j, r, rows, value, roll;
    int unsigned starts [5];
    int unsigned heights [5];
    lo_idx = 0;
    glyphs = 0;
    if (font_last < font_first) return;
    base_code = $urandom_range(font_first, font_last);
    lo_idx    = base_code - font_first;
    glyphs    = $urandom_range(2, 4);
    if (glyphs > 255 - lo_idx) glyphs = 255 - lo_idx;
    if (glyphs > 256 - base_code) glyphs = 256 - base_code;
    pos = $urandom_range(0, 4095);
    for (j = 0; j <= glyphs; j++) begin
      send_request(load_item(fgb_pkg::OP_LOAD_OFFSET, lo_idx + j, pos));
      starts[j] = pos;
      if (j < glyphs) begin
        heights[j] = glyph_height();
        pos = (pos + heights[j]) % 4096;
      end
    end
    for (j = 0; j < glyphs; j++) begin
      // a glyph whose end wrapped below its start is empty and reads nothing
      if (heights[j] != 0 && starts[j] + heights[j] < 4096) begin
        rows = (heights[j] > GLYPH_ROW_MAX) ? GLYPH_ROW_MAX : heights[j];
        for (r = 0; r < rows; r++) begin
          value = $urandom_range(0, 4095);
          roll  = $urandom_range(0, 9);
          if (roll == 0) value = value | 32'h0FF;
          else if (roll == 1) value = value & 32'hF00;
          send_request(load_item(fgb_pkg::OP_LOAD_GLYPH, starts[j] + r, value));
        end
      end
    end
  endtask

  // one font build followed by draws; squeeze holds the result side meanwhile
  task automatic font_round(input bit squeeze);
    int unsigned lo_idx, glyphs, draws, k, tries, roll;
    logic [7:0]  code;
    bit          found;
    gapless = ($urandom_range(0, 3) == 0);
    build_font(lo_idx, glyphs);
    if (squeeze) begin
      hold_results = 1'b1;
      gapless      = 1'b1;
    end
    draws = squeeze ? 14 : $urandom_range(6, 14);
    for (k = 0; k < draws; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_request(noise_item());
        continue;
      end
      found = 1'b0;
      for (tries = 0; tries < 8 && !found; tries++) begin
        roll = $urandom_range(0, 99);
        if (glyphs > 0 && roll < 75)
          code = 8'(font_first + lo_idx + $urandom_range(0, glyphs - 1));
        else if (roll < 80) code = 8'd255;
        else if (roll < 85) code = 8'd0;
        else code = 8'($urandom_range(0, 255));
        found = draw_reads_loaded(code);
      end
      if (found) send_request(draw_item(code));
      else send_request(load_item(OP_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 4095)));
    end
    gapless = 1'b0;
    if ($urandom_range(0, 9) == 0) wait_drained();
  endtask

  task automatic add_case(input logic [1:0] op, input int unsigned index,
                          input int unsigned value, input logic [7:0] code,
                          input int unsigned target, input bit typed = 1'b0,
                          input logic [1:0] st = fgb_pkg::STAT_OK);
    blit_case_t row;
    row.req.operation   = op;
    row.req.table_index = 12'(index);
    row.req.load_value  = 12'(value);
    row.req.char_code   = code;
    row.req.target_word = 14'(target);
    row.typed           = typed;
    row.result          = make_result(1'b0, 0, '0, st, 1'b1);
    directed_cases.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned phase, quota, i;
    logic [7:0]  first_val, last_val;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: codes just outside the reset font, dropped transactions,
    // pixel patterns, a clipped glyph at the screen end, an empty glyph and
    // a glyph of exactly the row limit at the largest target
    add_case(fgb_pkg::OP_DRAW, 12'h000, 12'h000, 8'd31, 0, 1'b1, fgb_pkg::STAT_RANGE);
    add_case(fgb_pkg::OP_DRAW, 12'hFFF, 12'hFFF, 8'd128, 16383, 1'b1, fgb_pkg::STAT_RANGE);
    add_case(OP_UNUSED, 12'hFFF, 12'hFFF, 8'hFF, 16383);
    add_case(fgb_pkg::OP_LOAD_OFFSET, 12'hFFF, 12'hFFF, 8'hFF, 16383);
    for (i = 0; i < 16; i++) add_case(fgb_pkg::OP_LOAD_GLYPH, i, probe_rows[i], 8'h00, 0);
    add_case(fgb_pkg::OP_LOAD_OFFSET, 0, 0, 8'h00, 0);
    add_case(fgb_pkg::OP_LOAD_OFFSET, 1, 17, 8'h00, 0);
    add_case(fgb_pkg::OP_LOAD_OFFSET, 2, 17, 8'h00, 0);
    add_case(fgb_pkg::OP_DRAW, 12'h000, 12'h000, 8'd32, fgb_pkg::SCREEN_WORDS - 1);
    add_case(fgb_pkg::OP_DRAW, 12'h000, 12'h000, 8'd33, 5, 1'b1, fgb_pkg::STAT_EMPTY);
    add_case(fgb_pkg::OP_LOAD_OFFSET, 1, 16, 8'h00, 0);
    add_case(fgb_pkg::OP_DRAW, 12'hFFF, 12'hFFF, 8'd32, 16383);
    foreach (directed_cases[i])
      send_request(directed_cases[i].req, directed_cases[i].typed, directed_cases[i].result);

    // random phases, each under its own code range
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (phase)
        0: begin first_val = 8'd0;   last_val = 8'd255; end
        1: begin first_val = 8'd255; last_val = 8'd255; end
        3: begin first_val = 8'd0;   last_val = 8'd0;   end
        4: begin first_val = 8'd200; last_val = 8'd90;  end
        NUM_PHASES - 1: begin first_val = 8'd32; last_val = 8'd127; end
        default: begin
          first_val = 8'($urandom_range(0, 200));
          last_val  = 8'((first_val + $urandom_range(0, 55) > 255) ? 255 :
                         first_val + $urandom_range(0, 55));
        end
      endcase
      if (phase % 2 == 0) begin
        write_register(fgb_pkg::REG_FIRST_CODE, first_val);
        write_register(fgb_pkg::REG_LAST_CODE, last_val);
      end else begin
        write_register(fgb_pkg::REG_LAST_CODE, last_val);
        write_register(fgb_pkg::REG_FIRST_CODE, first_val);
      end
      quota = items_sent + PHASE_ITEMS;
      font_round(phase == 2 || phase == 5);
      while (items_sent < quota) font_round(1'b0);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_fb_writes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0t: %0d mismatches, %0d results outstanding", $time, mismatch_count,
               pending_fb_writes.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
